// ===== hdl/bdne_pkg.sv =====
package bdne_pkg;

  // Field widths of the sample and event beats.
  localparam int IDX_W   = 6;
  localparam int NOTE_W  = 7;
  localparam int VEL_W   = 7;
  localparam int CNT_W   = 8;

  // Bank size default and configuration reset values.
  localparam int            NUM_BUTTONS_DEF    = 64;
  localparam logic [CNT_W-1:0] HOLD_THRESHOLD_RST = 8'd2;
  localparam logic [VEL_W-1:0] NOTE_VELOCITY_RST  = 7'd127;

  // Configuration register map.
  localparam int   APB_DATA_W = 32;
  localparam int   APB_ADDR_W = 3;
  localparam int   REG_IDX_W  = 1;
  localparam logic [REG_IDX_W-1:0] REG_HOLD_THRESHOLD = 1'd0;
  localparam logic [REG_IDX_W-1:0] REG_NOTE_VELOCITY  = 1'd1;

  // Note layout: six buttons per group, groups an octave apart.
  localparam int NOTES_PER_GROUP = 6;
  localparam int GROUP_STRIDE    = 12;
  // Division by six as a multiply by a reciprocal; exact for indexes below 128.
  localparam int DIV6_MUL   = 43;
  localparam int DIV6_SHIFT = 8;
  localparam int PROD_W     = IDX_W + 6;

  // Configuration seen by the datapath.
  typedef struct packed {
    logic [CNT_W-1:0] hold_threshold;
    logic [VEL_W-1:0] note_velocity;
  } cfg_t;

  // One stored entry per button.
  typedef struct packed {
    logic             level;
    logic [CNT_W-1:0] count;
  } entry_t;

  // Note number for a button index: group*12 + position in group.
  function automatic logic [NOTE_W-1:0] note_for(input logic [IDX_W-1:0] idx);
    logic [PROD_W-1:0] prod;
    logic [NOTE_W-1:0] grp;
    logic [NOTE_W-1:0] pos;
    prod = PROD_W'(idx) * PROD_W'(DIV6_MUL);
    grp  = NOTE_W'(prod >> DIV6_SHIFT);
    pos  = NOTE_W'(idx) - grp * NOTE_W'(NOTES_PER_GROUP);
    return grp * NOTE_W'(GROUP_STRIDE) + pos;
  endfunction

endpackage

// ===== hdl/button_debounce_note_events.sv =====
// Button debounce with note events.
//
// Sample channel (in_valid / in_stall): each beat carries one raw level for
// one button. A button index beyond the bank is dropped without effect.
// Event channel (out_valid / out_stall): a beat is produced only when a
// button's debounced level flips; it carries the note number, note on/off and
// the velocity (zero for note off).
// Configuration: APB write of hold_threshold at byte address 0 and
// note_velocity at byte address 4; pready is always high.
//
// Throughput is one sample per cycle while in_stall is low. Each sample does one
// read-modify-write of its button's entry in the state memory; the read
// latency is covered by forwarding the last write. A sample's event passes the
// lookup stage register and is then loaded into the output register.
// While the receiver stalls, the pending event is held; samples keep flowing
// until a second event is ready behind it, then in_stall rises.
// Reset clears all debounced levels and counters at once (per-entry valid
// flags) and loads threshold 2 and velocity 127; no clearing pass is needed.
module button_debounce_note_events #(
  parameter int NUM_BUTTONS = bdne_pkg::NUM_BUTTONS_DEF
) (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              in_valid,
  output logic                              in_stall,
  input  logic [bdne_pkg::IDX_W-1:0]        in_button_index,
  input  logic                              in_live_level,
  output logic                              out_valid,
  input  logic                              out_stall,
  output logic [bdne_pkg::NOTE_W-1:0]       out_note_number,
  output logic                              out_note_on,
  output logic [bdne_pkg::VEL_W-1:0]        out_velocity,
  input  logic                              psel,
  input  logic                              penable,
  input  logic                              pwrite,
  input  logic [bdne_pkg::APB_ADDR_W-1:0]   paddr,
  input  logic [bdne_pkg::APB_DATA_W-1:0]   pwdata,
  output logic [bdne_pkg::APB_DATA_W-1:0]   prdata,
  output logic                              pready
);

  logic [bdne_pkg::CNT_W-1:0]     hold_r;
  logic [bdne_pkg::VEL_W-1:0]     vel_r;
  logic [bdne_pkg::REG_IDX_W-1:0] reg_idx;
  logic                           wr_en;
  bdne_pkg::cfg_t                 cfg;

  assign pready  = 1'b1;
  assign reg_idx = paddr[bdne_pkg::APB_ADDR_W-1:2];
  assign wr_en   = psel && penable && pwrite && pready;

  // Configuration registers.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      hold_r <= bdne_pkg::HOLD_THRESHOLD_RST;
      vel_r  <= bdne_pkg::NOTE_VELOCITY_RST;
    end else if (wr_en) begin
      unique case (reg_idx)
        bdne_pkg::REG_HOLD_THRESHOLD: hold_r <= pwdata[bdne_pkg::CNT_W-1:0];
        bdne_pkg::REG_NOTE_VELOCITY:  vel_r  <= pwdata[bdne_pkg::VEL_W-1:0];
        default: ;
      endcase
    end
  end

  // Read back.
  always_comb begin
    unique case (reg_idx)
      bdne_pkg::REG_HOLD_THRESHOLD: prdata = bdne_pkg::APB_DATA_W'(hold_r);
      bdne_pkg::REG_NOTE_VELOCITY:  prdata = bdne_pkg::APB_DATA_W'(vel_r);
      default:                      prdata = '0;
    endcase
  end

  assign cfg.hold_threshold = hold_r;
  assign cfg.note_velocity  = vel_r;

  bdne_core #(
    .NUM_BUTTONS (NUM_BUTTONS)
  ) u_core (
    .clk             (clk),
    .rst_n           (rst_n),
    .cfg             (cfg),
    .in_valid        (in_valid),
    .in_stall        (in_stall),
    .in_button_index (in_button_index),
    .in_live_level   (in_live_level),
    .out_valid       (out_valid),
    .out_stall       (out_stall),
    .out_note_number (out_note_number),
    .out_note_on     (out_note_on),
    .out_velocity    (out_velocity)
  );

endmodule

// ===== hdl/bdne_ram.sv =====
module bdne_ram #(
  parameter int WIDTH = 9,
  parameter int DEPTH = 64
) (
  input  logic                                  clk,
  input  logic                                  we,
  input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] waddr,
  input  logic [WIDTH-1:0]                      wdata,
  input  logic                                  re,
  input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] raddr,
  output logic [WIDTH-1:0]                      rdata
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  // Single write port, registered read port; a read of the entry being
  // written returns the old contents.
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata_r <= mem[raddr];
    end
  end

  assign rdata = rdata_r;

endmodule

// ===== hdl/bdne_core.sv =====
module bdne_core #(
  parameter int NUM_BUTTONS = bdne_pkg::NUM_BUTTONS_DEF
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  bdne_pkg::cfg_t                cfg,
  input  logic                          in_valid,
  output logic                          in_stall,
  input  logic [bdne_pkg::IDX_W-1:0]    in_button_index,
  input  logic                          in_live_level,
  output logic                          out_valid,
  input  logic                          out_stall,
  output logic [bdne_pkg::NOTE_W-1:0]   out_note_number,
  output logic                          out_note_on,
  output logic [bdne_pkg::VEL_W-1:0]    out_velocity
);

  localparam int AW = (NUM_BUTTONS > 1) ? $clog2(NUM_BUTTONS) : 1;

  logic accept;
  logic in_range;

  // Lookup stage: the entry is being read from memory.
  logic          s1_vld_r, s1_vld_nxt;
  logic [AW-1:0] s1_idx_r;
  logic          s1_lvl_r;
  logic          s1_inr_r;

  // Last entry written, forwarded to a lookup that read stale data.
  logic                    fwd_vld_r;
  logic [AW-1:0]           fwd_idx_r;
  bdne_pkg::entry_t        fwd_data_r;

  logic [NUM_BUTTONS-1:0]  ent_vld_r;
  logic [$bits(bdne_pkg::entry_t)-1:0] ram_rdata;

  bdne_pkg::entry_t cur;
  bdne_pkg::entry_t upd;
  logic mism;
  logic flip;
  logic res;
  logic s1_adv;
  logic we;

  // Output register.
  logic                        out_vld_r;
  logic [bdne_pkg::NOTE_W-1:0] out_note_r;
  logic                        out_on_r;
  logic [bdne_pkg::VEL_W-1:0]  out_vel_r;

  assign in_range = {1'b0, in_button_index} < (bdne_pkg::IDX_W + 1)'(NUM_BUTTONS);
  assign accept   = in_valid && !in_stall;

  bdne_ram #(
    .WIDTH ($bits(bdne_pkg::entry_t)),
    .DEPTH (NUM_BUTTONS)
  ) u_state_ram (
    .clk   (clk),
    .we    (we),
    .waddr (s1_idx_r),
    .wdata (upd),
    .re    (accept),
    .raddr (in_button_index[AW-1:0]),
    .rdata (ram_rdata)
  );

  // Current entry: reset value for an out-of-range index or until first written, else the newest copy.
  always_comb begin
    if (!s1_inr_r || !ent_vld_r[s1_idx_r]) begin
      cur = '0;
    end else if (fwd_vld_r && (fwd_idx_r == s1_idx_r)) begin
      cur = fwd_data_r;
    end else begin
      cur = bdne_pkg::entry_t'(ram_rdata);
    end
  end

  // Debounce decision and the updated entry.
  always_comb begin
    mism = (s1_lvl_r != cur.level);
    flip = mism && (cur.count >= cfg.hold_threshold);
    res  = s1_inr_r && flip;
    upd  = cur;
    if (!mism) begin
      upd.count = '0;
    end else if (flip) begin
      upd.level = s1_lvl_r;
      upd.count = '0;
    end else if (cur.count != '1) begin
      upd.count = cur.count + 1'b1;
    end
  end

  // The lookup stage holds only when its event finds the output register blocked.
  assign s1_adv   = s1_vld_r && !(res && out_vld_r && out_stall);
  assign in_stall = s1_vld_r && res && out_vld_r && out_stall;
  assign we       = s1_adv && s1_inr_r;

  always_comb begin
    if (accept) begin
      s1_vld_nxt = 1'b1;
    end else if (s1_adv) begin
      s1_vld_nxt = 1'b0;
    end else begin
      s1_vld_nxt = s1_vld_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_vld_r  <= 1'b0;
      fwd_vld_r <= 1'b0;
      ent_vld_r <= '0;
    end else begin
      s1_vld_r <= s1_vld_nxt;
      if (we) begin
        fwd_vld_r           <= 1'b1;
        ent_vld_r[s1_idx_r] <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      s1_idx_r <= in_button_index[AW-1:0];
      s1_lvl_r <= in_live_level;
      s1_inr_r <= in_range;
    end
    if (we) begin
      fwd_idx_r  <= s1_idx_r;
      fwd_data_r <= upd;
    end
  end

  // Event beat register.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_vld_r <= 1'b0;
    end else if (s1_adv && res) begin
      out_vld_r <= 1'b1;
    end else if (!out_stall) begin
      out_vld_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_adv && res) begin
      out_note_r <= bdne_pkg::note_for(bdne_pkg::IDX_W'(s1_idx_r));
      out_on_r   <= s1_lvl_r;
      out_vel_r  <= s1_lvl_r ? cfg.note_velocity : '0;
    end
  end

  assign out_valid       = out_vld_r;
  assign out_note_number = out_note_r;
  assign out_note_on     = out_on_r;
  assign out_velocity    = out_vel_r;

`ifndef ASSERT_OFF
  // Input is held back only by a blocked event behind a full output register.
  a_stall_cause: assert property (@(posedge clk) disable iff (!rst_n)
    in_stall |-> (s1_vld_r && out_vld_r))
    else $error("input stalled without a blocked event");

  // An event is only ever raised by a sample that differs from the stored level.
  a_event_on_mismatch: assert property (@(posedge clk) disable iff (!rst_n)
    (s1_adv && res) |-> (s1_lvl_r != cur.level && upd.count == '0))
    else $error("event raised without a level change");

  // Every entry write is captured for forwarding to the next lookup.
  a_forward_capture: assert property (@(posedge clk) disable iff (!rst_n)
    we |=> (fwd_vld_r && fwd_idx_r == $past(s1_idx_r)))
    else $error("entry write not captured for forwarding");

  // A new event is loaded only when the previous one has left or is leaving.
  a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
    (s1_adv && res) |-> (!out_vld_r || !out_stall))
    else $error("pending event overwritten");
`endif

endmodule

// ===== bench/note_event_checker.sv =====
module note_event_checker
  import bdne_pkg::*;
(
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  in_valid,
  input  logic                  in_stall,
  input  logic [IDX_W-1:0]      in_button_index,
  input  logic                  in_live_level,
  input  logic                  out_valid,
  input  logic                  out_stall,
  input  logic [NOTE_W-1:0]     out_note_number,
  input  logic                  out_note_on,
  input  logic [VEL_W-1:0]      out_velocity,
  input  logic                  psel,
  input  logic                  penable,
  input  logic                  pwrite,
  input  logic [APB_ADDR_W-1:0] paddr,
  input  logic [APB_DATA_W-1:0] pwdata,
  input  logic [APB_DATA_W-1:0] prdata,
  input  logic                  pready,
  output int                    check_failures,
  output int                    events_pending
);

  localparam int BANK_SIZE          = 64;
  localparam int BUTTONS_PER_OCTAVE = 6;
  localparam int OCTAVE_STEPS       = 12;

  // One note event as it should appear on the event channel.
  typedef struct packed {
    logic [NOTE_W-1:0] note;
    logic              on;
    logic [VEL_W-1:0]  vel;
  } note_event_t;

  // Shadow of the debounce state and the configuration.
  logic             debounced_level [BANK_SIZE];
  logic [CNT_W-1:0] bounce_count [BANK_SIZE];
  logic [CNT_W-1:0] hold_thr;
  logic [VEL_W-1:0] note_vel;
  note_event_t      expected_notes [$];

  initial check_failures = 0;
  initial events_pending = 0;

  // Prints one line per mismatch and counts every one.
  task automatic report_mismatch(input string what);
    $display("[%0t] note event mismatch: %s", $time, what);
    check_failures++;
  endtask

  // Applies one sample to the shadow state; returns 1 when the level flips.
  function automatic bit debounce_sample(input logic [IDX_W-1:0] idx, input logic lvl,
                                         output note_event_t ev);
    ev = '0;
    if (lvl == debounced_level[idx]) begin
      bounce_count[idx] = '0;
      return 1'b0;
    end
    if (bounce_count[idx] >= hold_thr) begin
      bounce_count[idx]    = '0;
      debounced_level[idx] = lvl;
      ev.note = NOTE_W'((int'(idx) / BUTTONS_PER_OCTAVE) * OCTAVE_STEPS
                        + int'(idx) % BUTTONS_PER_OCTAVE);
      ev.on   = lvl;
      ev.vel  = lvl ? note_vel : '0;
      return 1'b1;
    end
    // The counter stops at its top value.
    if (bounce_count[idx] != '1) begin
      bounce_count[idx] = bounce_count[idx] + 1'b1;
    end
    return 1'b0;
  endfunction

  // Watch every channel at the clock edge, predict and compare.
  always @(posedge clk) begin
    note_event_t              want;
    note_event_t              fresh;
    logic [REG_IDX_W-1:0]     reg_sel;
    logic [APB_DATA_W-1:0]    reg_value;
    reg_sel = paddr[APB_ADDR_W-1:2];
    if (!rst_n) begin
      for (int i = 0; i < BANK_SIZE; i++) begin
        debounced_level[i] = 1'b0;
        bounce_count[i]    = '0;
      end
      hold_thr = HOLD_THRESHOLD_RST;
      note_vel = NOTE_VELOCITY_RST;
      expected_notes.delete();
    end else begin
      // Register writes and reads.
      if (psel && penable && pready) begin
        if (pwrite) begin
          if (reg_sel == REG_HOLD_THRESHOLD) begin
            hold_thr = pwdata[CNT_W-1:0];
          end else if (reg_sel == REG_NOTE_VELOCITY) begin
            note_vel = pwdata[VEL_W-1:0];
          end
        end else begin
          reg_value = (reg_sel == REG_HOLD_THRESHOLD) ? APB_DATA_W'(hold_thr)
                                                      : APB_DATA_W'(note_vel);
          if (prdata !== reg_value) begin
            report_mismatch($sformatf("register %0d read %0h, want %0h",
                                      reg_sel, prdata, reg_value));
          end
        end
      end

      // Event beats are checked against the oldest expectation.
      if (out_valid && !out_stall) begin
        if (expected_notes.size() == 0) begin
          report_mismatch($sformatf("event beat note %0d on %0b vel %0d with none expected",
                                    out_note_number, out_note_on, out_velocity));
        end else begin
          want = expected_notes.pop_front();
          if (out_note_number !== want.note) begin
            report_mismatch($sformatf("note_number %0d, want %0d",
                                      out_note_number, want.note));
          end
          if (out_note_on !== want.on) begin
            report_mismatch($sformatf("note_on %0b, want %0b (note %0d)",
                                      out_note_on, want.on, want.note));
          end
          if (out_velocity !== want.vel) begin
            report_mismatch($sformatf("velocity %0d, want %0d (note %0d)",
                                      out_velocity, want.vel, want.note));
          end
        end
      end

      // Each accepted sample beat updates the shadow state.
      if (in_valid && !in_stall) begin
        if (debounce_sample(in_button_index, in_live_level, fresh)) begin
          expected_notes.push_back(fresh);
        end
      end
    end
    events_pending = expected_notes.size();
  end

endmodule

// ===== bench/tb_button_debounce_note_events.sv =====
module tb_button_debounce_note_events;
  import bdne_pkg::*;

  localparam int DRAIN_CYCLES = 8;
  localparam int LONG_HOLD    = 300;
  localparam int TIMEOUT_CYC  = 200000;

  logic                  clk = 1'b0;
  logic                  rst_n = 1'b0;
  logic                  in_valid = 1'b0;
  logic                  in_stall;
  logic [IDX_W-1:0]      in_button_index = '0;
  logic                  in_live_level = 1'b0;
  logic                  out_valid;
  logic                  out_stall = 1'b0;
  logic [NOTE_W-1:0]     out_note_number;
  logic                  out_note_on;
  logic [VEL_W-1:0]      out_velocity;
  logic                  psel = 1'b0;
  logic                  penable = 1'b0;
  logic                  pwrite = 1'b0;
  logic [APB_ADDR_W-1:0] paddr = '0;
  logic [APB_DATA_W-1:0] pwdata = '0;
  logic [APB_DATA_W-1:0] prdata;
  logic                  pready;

  int check_failures;
  int events_pending;
  int send_gap_pct = 0;
  int recv_gap_pct = 0;
  logic hold_armed = 1'b0;
  int hold_cycles = 0;

  button_debounce_note_events DUT (
    .clk             (clk),
    .rst_n           (rst_n),
    .in_valid        (in_valid),
    .in_stall        (in_stall),
    .in_button_index (in_button_index),
    .in_live_level   (in_live_level),
    .out_valid       (out_valid),
    .out_stall       (out_stall),
    .out_note_number (out_note_number),
    .out_note_on     (out_note_on),
    .out_velocity    (out_velocity),
    .psel            (psel),
    .penable         (penable),
    .pwrite          (pwrite),
    .paddr           (paddr),
    .pwdata          (pwdata),
    .prdata          (prdata),
    .pready          (pready)
  );

  note_event_checker u_note_checker (
    .clk             (clk),
    .rst_n           (rst_n),
    .in_valid        (in_valid),
    .in_stall        (in_stall),
    .in_button_index (in_button_index),
    .in_live_level   (in_live_level),
    .out_valid       (out_valid),
    .out_stall       (out_stall),
    .out_note_number (out_note_number),
    .out_note_on     (out_note_on),
    .out_velocity    (out_velocity),
    .psel            (psel),
    .penable         (penable),
    .pwrite          (pwrite),
    .paddr           (paddr),
    .pwdata          (pwdata),
    .prdata          (prdata),
    .pready          (pready),
    .check_failures  (check_failures),
    .events_pending  (events_pending)
  );

  // Clock.
  initial begin
    forever #6 clk = ~clk;
  end

  // Hard limit on the run.
  initial begin
    #(12 * TIMEOUT_CYC);
    $display("CHECKS FAILED");
    $finish;
  end

  // Event receiver: one long hold-off when armed, otherwise random stalls.
  always @(posedge clk) begin
    if (hold_armed && hold_cycles < LONG_HOLD) begin
      out_stall   <= 1'b1;
      hold_cycles <= hold_cycles + 1;
    end else begin
      out_stall <= ($urandom_range(99) < recv_gap_pct);
    end
  end

  // Offers one sample beat, with random idle cycles ahead of it.
  task automatic send_sample(input logic [IDX_W-1:0] idx, input logic lvl);
    while (send_gap_pct != 0 && $urandom_range(99) < send_gap_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid        <= 1'b1;
    in_button_index <= idx;
    in_live_level   <= lvl;
    do @(posedge clk); while (in_stall);
  endtask

  // One register write or read: setup cycle, access cycle, then a free cycle.
  task automatic apb_transfer(input bit is_write, input logic [REG_IDX_W-1:0] reg_sel,
                              input logic [APB_DATA_W-1:0] value);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= is_write;
    paddr   <= {reg_sel, 2'b00};
    pwdata  <= value;
    @(posedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    psel    <= 1'b0;
    penable <= 1'b0;
    @(posedge clk);
  endtask

  // Stops offering samples and waits until every expected event has left.
  task automatic drain_events();
    in_valid <= 1'b0;
    @(posedge clk);
    while (events_pending != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  // Writes both registers while idle, then reads them back.
  task automatic reconfigure(input int thr, input int vel);
    drain_events();
    apb_transfer(1'b1, REG_HOLD_THRESHOLD, APB_DATA_W'(thr));
    apb_transfer(1'b1, REG_NOTE_VELOCITY, APB_DATA_W'(vel));
    apb_transfer(1'b0, REG_HOLD_THRESHOLD, '0);
    apb_transfer(1'b0, REG_NOTE_VELOCITY, '0);
  endtask

  // Scan traffic: a small pool of buttons held at steady levels long enough
  // to flip, with occasional bounces and samples from arbitrary buttons.
  task automatic send_scan_burst(input int n_items, input int run_min);
    logic [IDX_W-1:0] pool [4];
    logic             pool_level [4];
    int               pool_left [4];
    int               slot;
    logic             lvl;
    for (int k = 0; k < 4; k++) begin
      pool[k]       = IDX_W'($urandom_range(63));
      pool_level[k] = 1'($urandom_range(1));
      pool_left[k]  = run_min + $urandom_range(3);
    end
    for (int n = 0; n < n_items; n++) begin
      slot = $urandom_range(3);
      if ($urandom_range(99) < 10) begin
        send_sample(IDX_W'($urandom_range(63)), 1'($urandom_range(1)));
      end else begin
        lvl = pool_level[slot];
        if ($urandom_range(99) < 8) begin
          lvl = ~lvl;
        end
        send_sample(pool[slot], lvl);
        pool_left[slot]--;
        if (pool_left[slot] <= 0) begin
          pool_level[slot] = ~pool_level[slot];
          pool_left[slot]  = run_min + $urandom_range(3);
          if ($urandom_range(3) == 0) begin
            pool[slot] = IDX_W'($urandom_range(63));
          end
        end
      end
    end
  endtask

  // Stimulus and verdict.
  initial begin
    repeat (7) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Reset values of both registers.
    apb_transfer(1'b0, REG_HOLD_THRESHOLD, '0);
    apb_transfer(1'b0, REG_NOTE_VELOCITY, '0);

    // Default threshold: the third mismatch flips; a matching sample clears.
    repeat (3) send_sample(6'd0, 1'b1);
    send_sample(6'd63, 1'b1);
    send_sample(6'd63, 1'b1);
    send_sample(6'd63, 1'b0);
    repeat (3) send_sample(6'd63, 1'b1);
    repeat (3) send_sample(6'd0, 1'b0);
    repeat (3) send_sample(6'd42, 1'b1);

    // Zero threshold flips at once; zero velocity on note on.
    reconfigure(0, 0);
    send_sample(6'd21, 1'b1);
    send_sample(6'd21, 1'b0);
    send_sample(6'd63, 1'b0);

    // Top threshold: button 63 is settled low, the 256th mismatch flips it.
    reconfigure(255, 1);
    repeat (256) send_sample(6'd63, 1'b1);
    send_sample(6'd63, 1'b0);

    // Receiver idles more often than the sender at first.
    send_gap_pct = 38;
    recv_gap_pct <= 60;
    reconfigure(0, 127);
    send_scan_burst(20, 1);
    // Long receiver hold-off while samples keep coming.
    hold_armed <= 1'b1;
    send_scan_burst(50, 1);
    reconfigure(1, $urandom_range(127));
    send_scan_burst(50, 2);

    // Then the receiver idles less than the sender.
    send_gap_pct = 60;
    recv_gap_pct <= 38;
    reconfigure(3, 64);
    send_scan_burst(50, 4);
    reconfigure(2, $urandom_range(127));
    send_scan_burst(40, 3);

    // Finally neither side idles.
    send_gap_pct = 0;
    recv_gap_pct <= 0;
    reconfigure(4, 0);
    send_scan_burst(40, 5);
    reconfigure(0, $urandom_range(127));
    send_scan_burst(40, 1);

    drain_events();
    if (check_failures == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

endmodule
